// ----- rtl/hbd_pkg.sv -----
// shared constants and types for the hamming(31,26) block decoder
`timescale 1ns / 1ps
`default_nettype none

package hbd_pkg;

    localparam int CW_BITS    = 31;
    localparam int CODEWORDS  = 8;
    localparam int BLOCK_BITS = CW_BITS * CODEWORDS;
    localparam int OUT_BYTES  = 26;
    localparam int OUT_BITS   = OUT_BYTES * 8;
    localparam int POS_W      = $clog2(CW_BITS + 1);
    localparam int BLK_CNT_W  = $clog2(BLOCK_BITS);
    localparam int OUT_IDX_W  = $clog2(OUT_BYTES);
    localparam int CORR_W     = 4;

    localparam logic [POS_W-1:0]     POS_FIRST = POS_W'(1);
    localparam logic [POS_W-1:0]     POS_LAST  = POS_W'(CW_BITS);
    localparam logic [BLK_CNT_W-1:0] BLK_LAST  = BLK_CNT_W'(BLOCK_BITS - 1);
    localparam logic [OUT_IDX_W-1:0] OUT_LAST  = OUT_IDX_W'(OUT_BYTES - 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SHIFT = 4'b0010,
        ST_PAD   = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/hamming_31_26_block_decoder_core.sv -----
// hamming(31,26) block decoder: bit-serial syndrome, correction and parity strip
`timescale 1ns / 1ps
`default_nettype none

// Decodes blocks of 31 coded bytes (eight Hamming(31,26) codewords, msb first)
// into 26 data bytes. Each accepted byte is taken on the input beat and then
// shifted into the decoder one bit per cycle, so the slave side takes no new
// byte until the current one is shifted in. A beat with tuser set ends the
// stream: the rest of the block is filled with zero bits, one per cycle.
// Codeword bits first enter a 30-bit fill register that builds the syndrome
// as the positions go by; each finished codeword moves to a drain register
// that shifts it out, flips the bit that the syndrome names and drops the
// parity positions 1, 2, 4, 8 and 16. Filling of one codeword overlaps
// draining of the one before. After the last bit of a block, the drain
// empties and a load moves the data into the result register; then the 26
// result beats appear at the master side, one per cycle while m_tready is
// high, each carrying the block's count of corrected codewords; the last beat
// of the block has tlast set. Results are held in their own register, so the
// next block is taken in while results wait; the load waits for the drain to
// finish and for the previous block's results to be all taken.
module hamming_31_26_block_decoder_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic       s_tuser,   // [0] end_of_stream
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic [3:0]      m_tuser,   // [3:0] corrected_count
    output logic            m_tlast    // last_of_block
);
    import hbd_pkg::*;

    // input control
    state_t                 state_reg, state_next;
    logic [7:0]             byte_reg, byte_next;
    logic [2:0]             bit_idx_reg, bit_idx_next;
    logic                   eos_reg, eos_next;
    logic [BLK_CNT_W-1:0]   blk_cnt_reg, blk_cnt_next;

    // codeword fill stage
    logic [CW_BITS-2:0]     cw_reg, cw_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [POS_W-1:0]       syn_reg, syn_next;

    // codeword drain stage
    logic [CW_BITS-1:0]     drn_reg, drn_next;
    logic [POS_W-1:0]       drn_syn_reg, drn_syn_next;
    logic [POS_W-1:0]       drn_pos_reg, drn_pos_next;
    logic                   drn_busy_reg, drn_busy_next;

    // decoded data and result register
    logic [OUT_BITS-1:0]    data_reg, data_next;
    logic [CORR_W-1:0]      corr_reg, corr_next;
    logic [OUT_BITS-1:0]    out_reg, out_next;
    logic [CORR_W-1:0]      out_cnt_reg, out_cnt_next;
    logic [OUT_IDX_W-1:0]   out_idx_reg, out_idx_next;
    logic                   out_busy_reg, out_busy_next;

    logic                   feed;
    logic                   fbit;
    logic [POS_W-1:0]       syn_upd;
    logic                   a_done;
    logic                   dbit;
    logic                   is_parity;
    logic                   load;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_busy_reg;
    assign m_tdata  = out_reg[OUT_BITS-1 -: 8];
    assign m_tuser  = out_cnt_reg;
    assign m_tlast  = (out_idx_reg == OUT_LAST);

    // one code bit per cycle while shifting or padding: byte bits msb first, zeros while padding
    assign feed    = (state_reg == ST_SHIFT) || (state_reg == ST_PAD);
    assign fbit    = (state_reg == ST_SHIFT) && byte_reg[7];
    assign syn_upd = syn_reg ^ (fbit ? pos_reg : '0);
    assign a_done  = feed && (pos_reg == POS_LAST);

    // corrected bit leaving the drain; parity positions are powers of two
    assign dbit      = drn_reg[CW_BITS-1] ^ (drn_pos_reg == drn_syn_reg);
    assign is_parity = ((drn_pos_reg & (drn_pos_reg - POS_W'(1))) == '0);

    assign load = (state_reg == ST_FLUSH) && !drn_busy_reg && !out_busy_reg;

    always_comb
    begin
        state_next    = state_reg;
        byte_next     = byte_reg;
        bit_idx_next  = bit_idx_reg;
        eos_next      = eos_reg;
        blk_cnt_next  = blk_cnt_reg;
        cw_next       = cw_reg;
        pos_next      = pos_reg;
        syn_next      = syn_reg;
        drn_next      = drn_reg;
        drn_syn_next  = drn_syn_reg;
        drn_pos_next  = drn_pos_reg;
        drn_busy_next = drn_busy_reg;
        data_next     = data_reg;
        corr_next     = corr_reg;
        out_next      = out_reg;
        out_cnt_next  = out_cnt_reg;
        out_idx_next  = out_idx_reg;
        out_busy_next = out_busy_reg;

        // fill stage: shift in and accumulate syndrome
        if (feed)
        begin
            cw_next      = {cw_reg[CW_BITS-3:0], fbit};
            blk_cnt_next = blk_cnt_reg + BLK_CNT_W'(1);
            if (a_done)
            begin
                pos_next = POS_FIRST;
                syn_next = '0;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
                syn_next = syn_upd;
            end
        end

        // drain stage: correct, strip parity, pack data
        if (drn_busy_reg)
        begin
            drn_next     = {drn_reg[CW_BITS-2:0], 1'b0};
            drn_pos_next = drn_pos_reg + POS_W'(1);
            if (!is_parity)
            begin
                data_next = {data_reg[OUT_BITS-2:0], dbit};
            end
            if (drn_pos_reg == POS_LAST)
            begin
                drn_busy_next = 1'b0;
            end
        end

        // finished codeword hands over to the drain
        if (a_done)
        begin
            drn_next      = {cw_reg, fbit};
            drn_syn_next  = syn_upd;
            drn_pos_next  = POS_FIRST;
            drn_busy_next = 1'b1;
            if (syn_upd != '0)
            begin
                corr_next = corr_reg + CORR_W'(1);
            end
        end

        // result beats
        if (out_busy_reg && m_tready)
        begin
            out_next     = {out_reg[OUT_BITS-9:0], 8'h00};
            out_idx_next = out_idx_reg + OUT_IDX_W'(1);
            if (out_idx_reg == OUT_LAST)
            begin
                out_busy_next = 1'b0;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    byte_next    = s_tdata;
                    eos_next     = s_tuser;
                    bit_idx_next = '0;
                    state_next   = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                byte_next    = {byte_reg[6:0], 1'b0};
                bit_idx_next = bit_idx_reg + 3'd1;
                if (bit_idx_reg == 3'd7)
                begin
                    if (blk_cnt_reg == BLK_LAST)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else if (eos_reg)
                    begin
                        state_next = ST_PAD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_PAD:
            begin
                if (blk_cnt_reg == BLK_LAST)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (load)
                begin
                    out_next      = data_reg;
                    out_cnt_next  = corr_reg;
                    out_idx_next  = '0;
                    out_busy_next = 1'b1;
                    corr_next     = '0;
                    blk_cnt_next  = '0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            bit_idx_reg  <= '0;
            eos_reg      <= 1'b0;
            blk_cnt_reg  <= '0;
            pos_reg      <= POS_FIRST;
            syn_reg      <= '0;
            drn_pos_reg  <= POS_FIRST;
            drn_busy_reg <= 1'b0;
            corr_reg     <= '0;
            out_idx_reg  <= '0;
            out_busy_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            bit_idx_reg  <= bit_idx_next;
            eos_reg      <= eos_next;
            blk_cnt_reg  <= blk_cnt_next;
            pos_reg      <= pos_next;
            syn_reg      <= syn_next;
            drn_pos_reg  <= drn_pos_next;
            drn_busy_reg <= drn_busy_next;
            corr_reg     <= corr_next;
            out_idx_reg  <= out_idx_next;
            out_busy_reg <= out_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg    <= byte_next;
        cw_reg      <= cw_next;
        drn_reg     <= drn_next;
        drn_syn_reg <= drn_syn_next;
        data_reg    <= data_next;
        out_reg     <= out_next;
        out_cnt_reg <= out_cnt_next;
    end

`ifndef ASSERT_OFF
    // a new codeword reaches the drain only when it is idle or as the previous one finishes
    a_drain_free: assert property (@(posedge clk) disable iff (!rst_n)
        a_done |-> (!drn_busy_reg || drn_pos_reg == POS_LAST))
        else $error("codeword handed over while drain busy");

    // a block ends on a codeword boundary
    a_cw_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) |-> (pos_reg == POS_FIRST && syn_reg == '0))
        else $error("block flush not on codeword boundary");

    // at most one correction per codeword
    a_corr_range: assert property (@(posedge clk) disable iff (!rst_n)
        corr_reg <= CORR_W'(CODEWORDS))
        else $error("corrected count out of range");

    // the last result beat of a block frees the result register
    a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
        else $error("result register not freed after last beat");
`endif

endmodule

`default_nettype wire
